FILE: hdl/gbse_pkg.sv
`timescale 1ns / 1ps

package gbse_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = 13;
    localparam int SUM_W    = LEN_W + 1;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 3;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_HEADER = 2'd1,
        REQ_DATA   = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_READ_END   = 3'd1,
        ST_START_END  = 3'd2,
        ST_REMOVE_END = 3'd3,
        ST_NO_ROOM    = 3'd4,
        ST_SEQUENCE   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_MOVE_RD,
        S_MOVE_WR,
        S_OUT
    } t_state;

    // how the datapath classifies the latched request
    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_READ,
        CLS_MOVE
    } t_cls;

    typedef struct packed {
        logic latch_item;
        logic exec;
        logic rd_capture;
        logic move_rd;
        logic move_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic move_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/gap_buffer_splice_engine.sv
`timescale 1ns / 1ps

// channel  direction  handshake          fields
// request  in         i_valid / o_stall  req_type position remove_count insert_count data_byte
// result   out        o_valid / i_stall  read_byte status payload_length splice_done
//
// Reads pass from accept through the execute, read-wait and output states; data
// bytes, errors and splices that need no gap move skip the read wait.
// A splice that moves the gap first shifts |position + remove_count - gap_start|
// bytes: each moved byte is one read and one write on the byte store.
// Synchronous reset clears the pointers; store contents stay undefined, no clear pass.
// A finished result sits in the output register, so the next request is taken
// while it waits; o_stall is high from accept until a result is loaded, and a
// held result lengthens that only for the request behind it.

module gap_buffer_splice_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [gbse_pkg::LEN_W-1:0]    i_position,
    input  logic [gbse_pkg::LEN_W-1:0]    i_remove_count,
    input  logic [gbse_pkg::LEN_W-1:0]    i_insert_count,
    input  logic [gbse_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gbse_pkg::BYTE_W-1:0]   o_read_byte,
    output logic [gbse_pkg::STAT_W-1:0]   o_status,
    output logic [gbse_pkg::LEN_W-1:0]    o_payload_length,
    output logic                          o_splice_done
);

    gbse_pkg::t_dp_cmd  dp_cmd;
    gbse_pkg::t_dp_stat dp_stat;

    gbse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    gbse_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_remove_count   (i_remove_count),
        .i_insert_count   (i_insert_count),
        .i_data_byte      (i_data_byte),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_read_byte      (o_read_byte),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_splice_done    (o_splice_done)
    );

endmodule

FILE: hdl/gbse_ram.sv
`timescale 1ns / 1ps

module gbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/gbse_ctrl.sv
`timescale 1ns / 1ps

module gbse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  gbse_pkg::t_dp_stat i_stat,
    output gbse_pkg::t_dp_cmd  o_cmd
);

    gbse_pkg::t_state r_state;
    gbse_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbse_pkg::S_IDLE: begin
                if (i_valid) n_state = gbse_pkg::S_EXEC;
            end
            gbse_pkg::S_EXEC: begin
                unique case (i_stat.cls)
                    gbse_pkg::CLS_READ: n_state = gbse_pkg::S_RD_WAIT;
                    gbse_pkg::CLS_MOVE: n_state = gbse_pkg::S_MOVE_RD;
                    default:            n_state = gbse_pkg::S_OUT;
                endcase
            end
            gbse_pkg::S_RD_WAIT: n_state = gbse_pkg::S_OUT;
            gbse_pkg::S_MOVE_RD: n_state = gbse_pkg::S_MOVE_WR;
            gbse_pkg::S_MOVE_WR: begin
                n_state = i_stat.move_last ? gbse_pkg::S_OUT : gbse_pkg::S_MOVE_RD;
            end
            gbse_pkg::S_OUT: begin
                if (i_stat.out_free) n_state = gbse_pkg::S_IDLE;
            end
            default: n_state = gbse_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            gbse_pkg::S_IDLE: begin
                o_stall          = 1'b0;
                o_cmd.latch_item = i_valid;
            end
            gbse_pkg::S_EXEC:    o_cmd.exec       = 1'b1;
            gbse_pkg::S_RD_WAIT: o_cmd.rd_capture = 1'b1;
            gbse_pkg::S_MOVE_RD: o_cmd.move_rd    = 1'b1;
            gbse_pkg::S_MOVE_WR: o_cmd.move_wr    = 1'b1;
            gbse_pkg::S_OUT:     o_cmd.load_out   = i_stat.out_free;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_latch_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch_item |=> r_state == gbse_pkg::S_EXEC)
        else $error("accepted request did not go to execute");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbse_pkg::S_OUT && !i_stat.out_free) |=> r_state == gbse_pkg::S_OUT)
        else $error("result dropped while output register full");

    a_stall_outside_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gbse_pkg::S_IDLE) |-> o_stall)
        else $error("request taken outside idle");
`endif

endmodule

FILE: hdl/gbse_dp.sv
`timescale 1ns / 1ps

module gbse_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbse_pkg::t_dp_cmd              i_cmd,
    output gbse_pkg::t_dp_stat             o_stat,
    input  logic [1:0]                    i_req_type,
    input  logic [gbse_pkg::LEN_W-1:0]    i_position,
    input  logic [gbse_pkg::LEN_W-1:0]    i_remove_count,
    input  logic [gbse_pkg::LEN_W-1:0]    i_insert_count,
    input  logic [gbse_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [gbse_pkg::BYTE_W-1:0]   o_read_byte,
    output logic [gbse_pkg::STAT_W-1:0]   o_status,
    output logic [gbse_pkg::LEN_W-1:0]    o_payload_length,
    output logic                          o_splice_done
);

    // gap-buffer pointers
    logic [gbse_pkg::LEN_W-1:0]  r_gap_start;
    logic [gbse_pkg::LEN_W-1:0]  r_len;
    logic [gbse_pkg::LEN_W-1:0]  r_pending;
    logic [gbse_pkg::LEN_W-1:0]  r_wpos;

    // latched request
    logic [1:0]                  r_req;
    logic [gbse_pkg::LEN_W-1:0]  r_pos;
    logic [gbse_pkg::LEN_W-1:0]  r_rem;
    logic [gbse_pkg::LEN_W-1:0]  r_ins;
    logic [gbse_pkg::BYTE_W-1:0] r_dat;

    // result waiting for the output register
    logic [gbse_pkg::BYTE_W-1:0] r_res_byte;
    gbse_pkg::t_status           r_res_status;
    logic                        r_res_done;

    logic                        r_out_valid;
    logic [gbse_pkg::BYTE_W-1:0] r_out_byte;
    logic [gbse_pkg::STAT_W-1:0] r_out_status;
    logic [gbse_pkg::LEN_W-1:0]  r_out_len;
    logic                        r_out_done;

    logic [gbse_pkg::LEN_W-1:0]  free_bytes;
    logic [gbse_pkg::SUM_W-1:0]  target;
    logic [gbse_pkg::SUM_W-1:0]  rd_phys;
    logic [gbse_pkg::SUM_W-1:0]  wr_phys;
    logic [gbse_pkg::LEN_W-1:0]  gs_dec;
    logic [gbse_pkg::LEN_W-1:0]  gs_inc;
    logic [gbse_pkg::LEN_W-1:0]  gs_next;
    logic [gbse_pkg::SUM_W-1:0]  mv_src;
    logic [gbse_pkg::SUM_W-1:0]  mv_dst;
    logic                        mv_down;
    logic                        move_last;
    logic                        need_move;
    logic                        no_room;

    gbse_pkg::t_cls              cls;
    gbse_pkg::t_status           exec_status;
    logic                        hdr_apply;
    logic                        data_apply;
    logic                        hdr_finish;
    logic                        out_free;

    logic                        ram_wr_en;
    logic [gbse_pkg::ADDR_W-1:0] ram_wr_addr;
    logic [gbse_pkg::BYTE_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [gbse_pkg::ADDR_W-1:0] ram_rd_addr;
    logic [gbse_pkg::BYTE_W-1:0] ram_rd_data;

    assign free_bytes = gbse_pkg::CAP_LEN - r_len;
    assign target     = {1'b0, r_pos} + {1'b0, r_rem};

    // logical to physical: positions at or past the gap skip over it
    assign rd_phys = (r_pos >= r_gap_start) ? {1'b0, r_pos} + {1'b0, free_bytes}
                                            : {1'b0, r_pos};
    assign wr_phys = (r_wpos >= r_gap_start) ? {1'b0, r_wpos} + {1'b0, free_bytes}
                                             : {1'b0, r_wpos};

    // gap move: one byte per read/write pair, top byte first when moving down
    assign mv_down   = target < {1'b0, r_gap_start};
    assign gs_dec    = r_gap_start - 1'b1;
    assign gs_inc    = r_gap_start + 1'b1;
    assign gs_next   = mv_down ? gs_dec : gs_inc;
    assign mv_src    = mv_down ? {1'b0, gs_dec} : {1'b0, r_gap_start} + {1'b0, free_bytes};
    assign mv_dst    = mv_down ? {1'b0, gs_dec} + {1'b0, free_bytes} : {1'b0, r_gap_start};
    assign move_last = {1'b0, gs_next} == target;

    assign need_move = (r_ins != r_rem) && (r_len != gbse_pkg::CAP_LEN)
                       && (target != {1'b0, r_gap_start});
    assign no_room   = (r_ins > r_rem) && ((r_ins - r_rem) > free_bytes);

    always_comb begin
        cls         = gbse_pkg::CLS_SIMPLE;
        exec_status = gbse_pkg::ST_OK;
        hdr_apply   = 1'b0;
        data_apply  = 1'b0;
        case (r_req)
            gbse_pkg::REQ_READ: begin
                if (r_pending != '0) begin
                    exec_status = gbse_pkg::ST_SEQUENCE;
                end else if (r_pos >= r_len) begin
                    exec_status = gbse_pkg::ST_READ_END;
                end else begin
                    cls = gbse_pkg::CLS_READ;
                end
            end
            gbse_pkg::REQ_HEADER: begin
                if (r_pending != '0) begin
                    exec_status = gbse_pkg::ST_SEQUENCE;
                end else if (r_pos > r_len) begin
                    exec_status = gbse_pkg::ST_START_END;
                end else if (target > {1'b0, r_len}) begin
                    exec_status = gbse_pkg::ST_REMOVE_END;
                end else if (no_room) begin
                    exec_status = gbse_pkg::ST_NO_ROOM;
                end else if (need_move) begin
                    cls = gbse_pkg::CLS_MOVE;
                end else begin
                    hdr_apply = 1'b1;
                end
            end
            gbse_pkg::REQ_DATA: begin
                if (r_pending == '0) begin
                    exec_status = gbse_pkg::ST_SEQUENCE;
                end else begin
                    data_apply = 1'b1;
                end
            end
            default: exec_status = gbse_pkg::ST_SEQUENCE;
        endcase
    end

    assign hdr_finish = (i_cmd.exec && hdr_apply) || (i_cmd.move_wr && move_last);
    assign out_free   = !r_out_valid || !i_stall;

    assign o_stat.cls       = cls;
    assign o_stat.move_last = move_last;
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_start <= '0;
            r_len       <= '0;
            r_pending   <= '0;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (hdr_finish) begin
                if (r_ins != r_rem) begin
                    r_gap_start <= r_pos + r_ins;
                    r_len       <= r_len - r_rem + r_ins;
                end
                r_pending <= r_ins;
                r_wpos    <= r_pos;
            end else if (i_cmd.move_wr) begin
                r_gap_start <= gs_next;
            end
            if (i_cmd.exec && data_apply) begin
                r_wpos    <= r_wpos + 1'b1;
                r_pending <= r_pending - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_rem <= i_remove_count;
            r_ins <= i_insert_count;
            r_dat <= i_data_byte;
        end
        if (i_cmd.exec) begin
            r_res_status <= exec_status;
            r_res_byte   <= '0;
            r_res_done   <= (hdr_apply && r_ins == '0)
                            || (data_apply && r_pending == gbse_pkg::LEN_W'(1));
        end
        if (i_cmd.rd_capture) begin
            r_res_byte <= ram_rd_data;
        end
        if (i_cmd.move_wr && move_last) begin
            r_res_done <= (r_ins == '0);
        end
        if (i_cmd.load_out) begin
            r_out_byte   <= r_res_byte;
            r_out_status <= r_res_status;
            r_out_len    <= r_len;
            r_out_done   <= r_res_done;
        end
    end

    assign ram_wr_en   = i_cmd.move_wr
                         || (i_cmd.exec && data_apply && r_wpos < r_len);
    assign ram_wr_addr = i_cmd.move_wr ? mv_dst[gbse_pkg::ADDR_W-1:0]
                                       : wr_phys[gbse_pkg::ADDR_W-1:0];
    assign ram_wr_data = i_cmd.move_wr ? ram_rd_data : r_dat;
    assign ram_rd_en   = i_cmd.move_rd || (i_cmd.exec && cls == gbse_pkg::CLS_READ);
    assign ram_rd_addr = i_cmd.move_rd ? mv_src[gbse_pkg::ADDR_W-1:0]
                                       : rd_phys[gbse_pkg::ADDR_W-1:0];

    gbse_ram #(
        .WIDTH (gbse_pkg::BYTE_W),
        .DEPTH (gbse_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid          = r_out_valid;
    assign o_read_byte      = r_out_byte;
    assign o_status         = r_out_status;
    assign o_payload_length = r_out_len;
    assign o_splice_done    = r_out_done;

`ifndef SYNTHESIS
    a_gap_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_start <= r_len && r_len <= gbse_pkg::CAP_LEN)
        else $error("gap start or length out of range");

    a_splice_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wpos} + {1'b0, r_pending}) <= {1'b0, r_len})
        else $error("pending splice runs past payload end");

    a_move_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.move_wr && !move_last) |=> $stable(r_len))
        else $error("payload length changed during gap move");
`endif

endmodule

FILE: tb/gap_buffer_splice_engine_tb.sv
`timescale 1ns / 1ps

module gap_buffer_splice_engine_tb;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int TEXT_SOFT_MAX = 200;

    typedef struct packed {
        logic [gbse_pkg::BYTE_W-1:0] rd_byte;
        gbse_pkg::t_status           status;
        logic [gbse_pkg::LEN_W-1:0]  len;
        logic                        done;
    } t_reply;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [1:0]                    i_req_type;
    logic [gbse_pkg::LEN_W-1:0]    i_position;
    logic [gbse_pkg::LEN_W-1:0]    i_remove_count;
    logic [gbse_pkg::LEN_W-1:0]    i_insert_count;
    logic [gbse_pkg::BYTE_W-1:0]   i_data_byte;
    logic                          o_valid;
    logic                          i_stall;
    logic [gbse_pkg::BYTE_W-1:0]   o_read_byte;
    logic [gbse_pkg::STAT_W-1:0]   o_status;
    logic [gbse_pkg::LEN_W-1:0]    o_payload_length;
    logic                          o_splice_done;

    // shadow copy of the gap buffer
    logic [gbse_pkg::BYTE_W-1:0]   text_mem [gbse_pkg::CAPACITY];
    int                            text_gap_start;
    int                            text_len;
    int                            splice_left;
    int                            splice_wr_pos;

    t_reply                        reply_q[$];
    int                            send_idle_pct;
    int                            recv_stall_pct;
    int                            accepted_ok;
    int                            reply_seq;
    int                            mismatch_count;

    gap_buffer_splice_engine i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_remove_count   (i_remove_count),
        .i_insert_count   (i_insert_count),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_byte      (o_read_byte),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_splice_done    (o_splice_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("gap_buffer_splice_engine verification failed");
        $finish;
    end

    function automatic int to_physical(input int logical);
        return (logical >= text_gap_start) ? logical + gbse_pkg::CAPACITY - text_len
                                           : logical;
    endfunction

    function automatic t_reply apply_request(input logic [1:0] req, input int pos,
                                             input int rem, input int ins,
                                             input logic [gbse_pkg::BYTE_W-1:0] dat);
        t_reply r;
        int     gap;
        int     tgt;
        r = '{rd_byte: '0, status: gbse_pkg::ST_OK, len: '0, done: 1'b0};
        gap = gbse_pkg::CAPACITY - text_len;
        case (req)
            gbse_pkg::REQ_READ: begin
                if (splice_left != 0)
                    r.status = gbse_pkg::ST_SEQUENCE;
                else if (pos >= text_len)
                    r.status = gbse_pkg::ST_READ_END;
                else
                    r.rd_byte = text_mem[to_physical(pos)];
            end
            gbse_pkg::REQ_HEADER: begin
                if (splice_left != 0) begin
                    r.status = gbse_pkg::ST_SEQUENCE;
                end else if (pos > text_len) begin
                    r.status = gbse_pkg::ST_START_END;
                end else if (pos + rem > text_len) begin
                    r.status = gbse_pkg::ST_REMOVE_END;
                end else if (ins > rem && ins - rem > gap) begin
                    r.status = gbse_pkg::ST_NO_ROOM;
                end else begin
                    if (ins != rem) begin
                        // slide the gap to the end of the removed span, then resize it
                        tgt = pos + rem;
                        if (gap != 0) begin
                            if (tgt < text_gap_start) begin
                                for (int i = text_gap_start - tgt - 1; i >= 0; i--)
                                    text_mem[tgt + gap + i] = text_mem[tgt + i];
                            end else begin
                                for (int i = 0; i < tgt - text_gap_start; i++)
                                    text_mem[text_gap_start + i] =
                                        text_mem[text_gap_start + gap + i];
                            end
                        end
                        text_gap_start = pos + ins;
                        text_len = text_len - rem + ins;
                    end
                    splice_left = ins;
                    splice_wr_pos = pos;
                    r.done = (ins == 0);
                end
            end
            gbse_pkg::REQ_DATA: begin
                if (splice_left == 0) begin
                    r.status = gbse_pkg::ST_SEQUENCE;
                end else begin
                    if (splice_wr_pos < text_len)
                        text_mem[to_physical(splice_wr_pos)] = dat;
                    splice_wr_pos++;
                    splice_left--;
                    r.done = (splice_left == 0);
                end
            end
            default: r.status = gbse_pkg::ST_SEQUENCE;
        endcase
        r.len = gbse_pkg::LEN_W'(text_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want_val, input int got_val);
        mismatch_count++;
        $display("ERROR reply %0d %s: expected %0d, got %0d",
                 reply_seq, what, want_val, got_val);
    endtask

    always @(posedge i_clk) begin : reply_checker
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            reply_seq++;
            if (reply_q.size() == 0) begin
                report_mismatch("reply with no request outstanding", 0, 1);
            end else begin
                want = reply_q.pop_front();
                if (o_read_byte !== want.rd_byte)
                    report_mismatch("read_byte", int'(want.rd_byte), int'(o_read_byte));
                if (o_status !== want.status)
                    report_mismatch("status", int'(want.status), int'(o_status));
                if (o_payload_length !== want.len)
                    report_mismatch("payload_length", int'(want.len),
                                    int'(o_payload_length));
                if (o_splice_done !== want.done)
                    report_mismatch("splice_done", int'(want.done), int'(o_splice_done));
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // returns at the edge where the request was taken
    task automatic send_request(input logic [1:0] req, input int pos, input int rem,
                                input int ins, input int dat);
        t_reply                      r;
        logic [gbse_pkg::LEN_W-1:0]  pos_bits;
        logic [gbse_pkg::LEN_W-1:0]  rem_bits;
        logic [gbse_pkg::LEN_W-1:0]  ins_bits;
        logic [gbse_pkg::BYTE_W-1:0] dat_bits;
        pos_bits = gbse_pkg::LEN_W'(pos);
        rem_bits = gbse_pkg::LEN_W'(rem);
        ins_bits = gbse_pkg::LEN_W'(ins);
        dat_bits = gbse_pkg::BYTE_W'(dat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_position     <= pos_bits;
        i_remove_count <= rem_bits;
        i_insert_count <= ins_bits;
        i_data_byte    <= dat_bits;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        r = apply_request(req, int'(pos_bits), int'(rem_bits), int'(ins_bits), dat_bits);
        reply_q.push_back(r);
        if (r.status == gbse_pkg::ST_OK)
            accepted_ok++;
    endtask

    task automatic wait_for_replies();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (reply_q.size() != 0);
    endtask

    task automatic read_at(input int pos);
        send_request(gbse_pkg::REQ_READ, pos, $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(255));
    endtask

    // header plus its data bytes, with the odd out-of-order request mixed in
    task automatic splice_with_data(input int pos, input int rem, input int ins);
        send_request(gbse_pkg::REQ_HEADER, pos, rem, ins, $urandom_range(255));
        while (splice_left != 0) begin
            if ($urandom_range(19) == 0)
                send_request($urandom_range(1) ? gbse_pkg::REQ_READ : gbse_pkg::REQ_HEADER,
                             $urandom_range(8191), $urandom_range(8191),
                             $urandom_range(8191), $urandom_range(255));
            send_request(gbse_pkg::REQ_DATA, $urandom_range(8191), $urandom_range(8191),
                         $urandom_range(8191), $urandom_range(255));
        end
    endtask

    task automatic test_empty_store();
        read_at(0);
        read_at(8191);
        send_request(gbse_pkg::REQ_DATA, 0, 0, 0, 8'hFF);
        send_request(REQ_UNKNOWN, 13'h1FFF, 13'h1FFF, 13'h1FFF, 8'hFF);
        send_request(gbse_pkg::REQ_HEADER, 1, 0, 0, 0);
        send_request(gbse_pkg::REQ_HEADER, 0, 1, 0, 0);
        send_request(gbse_pkg::REQ_HEADER, 0, 0, 13'h1FFF, 0);
        send_request(gbse_pkg::REQ_HEADER, 0, 0, 0, 0);
    endtask

    task automatic test_small_edits();
        send_request(gbse_pkg::REQ_HEADER, 0, 0, 8, 0);
        read_at(0);
        send_request(gbse_pkg::REQ_HEADER, 0, 0, 1, 0);
        send_request(gbse_pkg::REQ_DATA, 0, 0, 0, 8'h00);
        send_request(gbse_pkg::REQ_DATA, 0, 0, 0, 8'hFF);
        while (splice_left != 0)
            send_request(gbse_pkg::REQ_DATA, 0, 0, 0, $urandom_range(255));
        splice_with_data(3, 0, 2);
        splice_with_data(1, 3, 0);
        splice_with_data(0, 2, 2);
        splice_with_data(text_len, 0, 3);
        send_request(gbse_pkg::REQ_HEADER, text_len, 1, 0, 0);
        read_at(text_len);
        for (int p = 0; p < text_len; p++)
            read_at(p);
    endtask

    task automatic test_full_store();
        splice_with_data(0, text_len, 0);
        splice_with_data(0, 0, gbse_pkg::CAPACITY);
        read_at(0);
        read_at(gbse_pkg::CAPACITY - 1);
        read_at(gbse_pkg::CAPACITY);
        send_request(gbse_pkg::REQ_HEADER, 0, 0, 1, 0);
        send_request(gbse_pkg::REQ_HEADER, gbse_pkg::CAPACITY, 0, 1, 0);
        send_request(gbse_pkg::REQ_HEADER, gbse_pkg::CAPACITY, 0, 0, 0);
        splice_with_data(2048, 1, 1);
        // gap is empty here: the shrink only repositions it
        splice_with_data(4000, 96, 0);
        // long gap moves in both directions
        splice_with_data(0, 0, 1);
        read_at(0);
        read_at(1);
        read_at(4000);
        splice_with_data(3, 3998, 0);
        for (int p = 0; p < text_len; p++)
            read_at(p);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int goal;
        int pick;
        int pos;
        int rem;
        int ins;
        int max_rem;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        goal = accepted_ok + count;
        while (accepted_ok < goal) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (text_len > 0 && $urandom_range(9) != 0)
                    read_at($urandom_range(text_len - 1));
                else
                    read_at(text_len + $urandom_range(3));
            end else if (pick < 85) begin
                pos = $urandom_range(text_len);
                max_rem = text_len - pos;
                rem = $urandom_range(max_rem < 12 ? max_rem : 12);
                if ($urandom_range(9) == 0)
                    rem = $urandom_range(max_rem);
                if (text_len > TEXT_SOFT_MAX)
                    ins = $urandom_range(rem);
                else if (text_len < 16)
                    ins = rem + $urandom_range(12);
                else
                    ins = $urandom_range(12);
                if ($urandom_range(5) == 0)
                    ins = rem;
                splice_with_data(pos, rem, ins);
            end else if (pick < 92) begin
                if ($urandom_range(1)) begin
                    send_request(gbse_pkg::REQ_HEADER, text_len + 1 + $urandom_range(3),
                                 $urandom_range(4), $urandom_range(4), 0);
                end else begin
                    pos = $urandom_range(text_len);
                    send_request(gbse_pkg::REQ_HEADER, pos,
                                 text_len - pos + 1 + $urandom_range(3),
                                 $urandom_range(4), 0);
                end
            end else begin
                send_request(2'($urandom_range(3)), $urandom_range(8191),
                             $urandom_range(8191), $urandom_range(8191),
                             $urandom_range(255));
                // a stray header that happens to be legal still needs its bytes
                while (splice_left != 0)
                    send_request(gbse_pkg::REQ_DATA, 0, 0, 0, $urandom_range(255));
            end
        end
        wait_for_replies();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_stall        <= 1'b0;
        i_req_type     <= gbse_pkg::REQ_READ;
        i_position     <= '0;
        i_remove_count <= '0;
        i_insert_count <= '0;
        i_data_byte    <= '0;
        text_gap_start = 0;
        text_len       = 0;
        splice_left    = 0;
        splice_wr_pos  = 0;
        accepted_ok    = 0;
        reply_seq      = 0;
        mismatch_count = 0;
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        for (int i = 0; i < gbse_pkg::CAPACITY; i++)
            text_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_small_edits();
        test_full_store();
        wait_for_replies();
        test_random_traffic(0, 0, 312);
        test_random_traffic(71, 0, 312);
        test_random_traffic(0, 71, 312);
        test_random_traffic(17, 17, 314);

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("gap_buffer_splice_engine verification clean");
        else
            $display("gap_buffer_splice_engine verification failed");
        $finish;
    end

endmodule
